@@ rtl/wrs_pkg.sv @@
// Shared constants, widths and controller/datapath command types for the running stats unit.
package wrs_pkg;

  localparam int SampleWidthDef = 32;
  localparam int FracBitsDef    = 16;
  localparam int CountWidthDef  = 32;

  localparam int AccWidth   = 64;
  localparam int OutWidth   = 32;
  localparam int SqrtWidth  = AccWidth / 2;

  // tdata layout on the master side, lowest bits first; zero pad above variance_valid
  localparam int OutDataBits = 4 * OutWidth + AccWidth + OutWidth + 1;
  localparam int OutDataWidth = ((OutDataBits + 7) / 8) * 8;

  // command bundle from controller to datapath
  typedef struct packed {
    logic load;       // capture sample, bump count, start mean division
    logic div_step;   // one quotient bit
    logic mean_upd;   // apply quotient to mean
    logic mul_stage;  // register product
    logic acc_upd;    // accumulate M2, update min/max
    logic var_init;   // load variance division
    logic sqrt_init;  // load square root
    logic sqrt_step;  // one root bit
    logic out_load;   // capture result
  } wrs_cmd_t;

endpackage

@@ rtl/wrs_datapath.sv @@
// Datapath: Welford state, shared restoring divider, saturating multiply, iterative square root.
module wrs_datapath #(
  parameter int SampleWidth = wrs_pkg::SampleWidthDef,
  parameter int CountWidth  = wrs_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wrs_pkg::wrs_cmd_t             cmd_i,
  input  logic [SampleWidth-1:0]        sample_i,
  output logic                          var_valid_o,
  output logic [wrs_pkg::OutDataWidth-1:0] result_o
);

  localparam int AW = wrs_pkg::AccWidth;
  localparam int SW = SampleWidth + 2;   // delta headroom
  localparam int DW = AW;                // divider width
  localparam int RW = wrs_pkg::SqrtWidth;
  localparam int MW = SampleWidth;       // |delta| < 2^SampleWidth
  localparam int PW = (2 * MW > AW) ? 2 * MW : AW;
  localparam logic [CountWidth-1:0] CMax = {CountWidth{1'b1}};

  logic [CountWidth-1:0]        count_q;
  logic signed [SampleWidth-1:0] mean_q, min_q, max_q, smp_q;
  logic [AW-1:0]                m2_q;

  // divider: restoring, quotient shifts into dividend register
  logic [DW-1:0] dq_q, dr_q, dd_q;
  logic          dneg_q;
  logic signed [SW-1:0] delta_q, delta2;
  logic [AW-1:0] prod_q;

  // square root
  logic [AW-1:0] sx_q;
  logic [AW-1:0] srem_q;
  logic [RW-1:0] sroot_q;

  logic [AW-1:0] var_q;
  logic [wrs_pkg::OutDataWidth-1:0] res_q;

  logic [DW:0]   dtrial;
  logic [DW-1:0] dnext_r;
  logic [CountWidth-1:0] cnt_n;
  logic signed [SW-1:0] delta_n, quo_s, mean_n;
  logic [SW-1:0] mag_d;
  logic [AW+1:0] strial_rem;
  logic [AW+1:0] strial_sub;
  logic [MW-1:0] mag1, mag2;
  logic [2*MW-1:0] prod_raw;
  logic [PW-1:0] prod_ext;
  logic          prod_neg;
  logic [AW:0]   m2_sum;

  assign cnt_n   = (count_q == CMax) ? count_q : count_q + CountWidth'(1);
  assign delta_n = SW'(signed'(sample_i)) - SW'(mean_q);
  assign mag_d   = delta_n[SW-1] ? SW'(-delta_n) : SW'(delta_n);

  assign dtrial  = {dr_q, dq_q[DW-1]} - {1'b0, dd_q};
  assign dnext_r = dtrial[DW] ? {dr_q[DW-2:0], dq_q[DW-1]} : dtrial[DW-1:0];

  assign quo_s  = dneg_q ? SW'(-signed'(SW'(dq_q))) : signed'(SW'(dq_q));
  assign mean_n = SW'(mean_q) + quo_s;
  assign delta2 = SW'(smp_q) - SW'(mean_q);

  // both magnitudes fit in SampleWidth bits
  assign mag1 = MW'(delta_q[SW-1] ? -delta_q : delta_q);
  assign mag2 = MW'(delta2[SW-1] ? -delta2 : delta2);
  assign prod_raw = mag1 * mag2;
  assign prod_ext = PW'(prod_raw);
  // opposite signs give a zero contribution
  assign prod_neg = (delta_q[SW-1] && delta2 > 0) ||
                    (!delta_q[SW-1] && delta_q != 0 && delta2[SW-1]);
  assign m2_sum = {1'b0, m2_q} + {1'b0, prod_q};

  assign strial_rem = {srem_q, sx_q[AW-1:AW-2]};
  assign strial_sub = strial_rem - {{(AW-RW){1'b0}}, sroot_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mean_q  <= '0;
      m2_q    <= '0;
      min_q   <= {1'b0, {(SampleWidth-1){1'b1}}};
      max_q   <= {1'b1, {(SampleWidth-1){1'b0}}};
    end else begin
      if (cmd_i.load) count_q <= cnt_n;
      if (cmd_i.mean_upd) mean_q <= SampleWidth'(mean_n);
      if (cmd_i.acc_upd) begin
        m2_q <= m2_sum[AW] ? '1 : m2_sum[AW-1:0];
        if (smp_q < min_q) min_q <= smp_q;
        if (smp_q > max_q) max_q <= smp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q   <= sample_i;
      delta_q <= delta_n;
      dneg_q  <= delta_n[SW-1];
      dq_q    <= DW'(mag_d);
      dr_q    <= '0;
      dd_q    <= DW'(cnt_n);
    end else if (cmd_i.var_init) begin
      dneg_q <= 1'b0;
      dq_q   <= m2_q;
      dr_q   <= '0;
      dd_q   <= DW'(count_q - CountWidth'(1));
    end else if (cmd_i.div_step) begin
      dr_q <= dnext_r;
      dq_q <= {dq_q[DW-2:0], ~dtrial[DW]};
    end
    if (cmd_i.mul_stage) begin
      prod_q <= prod_neg ? '0 :
                ((prod_ext > PW'({AW{1'b1}})) ? '1 : prod_ext[AW-1:0]);
    end
    if (cmd_i.sqrt_init) begin
      var_q   <= dq_q;
      sx_q    <= dq_q;
      srem_q  <= '0;
      sroot_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sx_q <= {sx_q[AW-3:0], 2'b00};
      if (!strial_sub[AW+1]) begin
        srem_q  <= strial_sub[AW-1:0];
        sroot_q <= {sroot_q[RW-2:0], 1'b1};
      end else begin
        srem_q  <= strial_rem[AW-1:0];
        sroot_q <= {sroot_q[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      res_q <= wrs_pkg::OutDataWidth'({
        (count_q >= CountWidth'(2)),
        (count_q >= CountWidth'(2)) ? sroot_q : RW'(0),
        (count_q >= CountWidth'(2)) ? var_q : AW'(0),
        wrs_pkg::OutWidth'(max_q), wrs_pkg::OutWidth'(min_q),
        wrs_pkg::OutWidth'(mean_q), wrs_pkg::OutWidth'(count_q)});
    end
  end

  assign var_valid_o = (count_q >= CountWidth'(2));
  assign result_o    = res_q;

endmodule

@@ rtl/wrs_ctrl.sv @@
// Controller: per sample runs division, multiply, accumulate, variance div if count > 1, root.
module wrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              var_valid_i,
  output wrs_pkg::wrs_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MDIV  = 4'd1;
  localparam logic [3:0] S_MUPD  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_VINIT = 4'd5;
  localparam logic [3:0] S_VDIV  = 4'd6;
  localparam logic [3:0] S_SINIT = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam int DivSteps  = wrs_pkg::AccWidth;
  localparam int SqrtSteps = wrs_pkg::SqrtWidth;

  logic [3:0] state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic       ovld_q, ovld_d;
  logic       take;

  assign in_ready_o  = (state_q == S_IDLE);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    ovld_d  = ovld_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: if (take) begin
        cmd_o.load = 1'b1; cnt_d = '0; state_d = S_MDIV;
      end
      S_MDIV: begin
        cmd_o.div_step = 1'b1; cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(DivSteps - 1)) state_d = S_MUPD;
      end
      S_MUPD: begin cmd_o.mean_upd = 1'b1; state_d = S_MUL; end
      S_MUL:  begin cmd_o.mul_stage = 1'b1; state_d = S_ACC; end
      S_ACC:  begin cmd_o.acc_upd = 1'b1; state_d = S_VINIT; end
      S_VINIT: begin
        cmd_o.var_init = 1'b1; cnt_d = '0;
        state_d = var_valid_i ? S_VDIV : S_SINIT;
      end
      S_VDIV: begin
        cmd_o.div_step = 1'b1; cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(DivSteps - 1)) state_d = S_SINIT;
      end
      S_SINIT: begin cmd_o.sqrt_init = 1'b1; cnt_d = '0; state_d = S_SQRT; end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1; cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(SqrtSteps - 1)) state_d = S_OUT;
      end
      S_OUT: if (!ovld_q || out_ready_i) begin
        cmd_o.out_load = 1'b1; ovld_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> state_q == S_MDIV) else $error("accept did not start division");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !out_ready_i |=> ovld_q) else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("conflicting commands");

endmodule

@@ rtl/welford_running_stats.sv @@
// Top level of the Welford running statistics unit.
// Usage:
//  - Slave channel s_axis_*: one beat carries a signed Q15.16 sample.
//  - Master channel m_axis_*: one beat per sample with count, mean, min,
//    max, variance (Q32.32), std dev (Q16.16) and a variance-valid flag.
//  - Each sample runs from accept to result valid through a 64-step
//    restoring division by the count for the mean, a saturating multiply,
//    a 64-step division by count-1 for the variance, and a 32-step square
//    root, all on one shared divider and one root unit sequenced by the
//    controller. Below two samples the variance division is skipped.
//  - One sample is in flight at a time; the next beat is accepted once the
//    result is in the output register, even if the receiver has not taken it.
//  - If the receiver stalls, the finished result waits in the output
//    register and the next result waits at the end of its sequence.
//  - Reset clears count, mean and M2, sets min to the most positive and max
//    to the most negative value, and empties the output register.
module welford_running_stats #(
  parameter int SampleWidth = wrs_pkg::SampleWidthDef,
  parameter int CountWidth  = wrs_pkg::CountWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [SampleWidth-1:0]           s_axis_tdata,  // sample
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sample_count, mean, minimum, maximum, variance, std_dev, variance_valid
  output logic [wrs_pkg::OutDataWidth-1:0] m_axis_tdata
);

  wrs_pkg::wrs_cmd_t cmd;
  logic              var_valid;

  wrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .var_valid_i (var_valid),
    .cmd_o       (cmd)
  );

  wrs_datapath #(
    .SampleWidth (SampleWidth),
    .CountWidth  (CountWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (s_axis_tdata),
    .var_valid_o (var_valid),
    .result_o    (m_axis_tdata)
  );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the Welford running statistics unit.
`timescale 1ns / 1ps

module tb;

  localparam int CntW = 32;
  localparam int RandItems = 1300;
  localparam longint CycleLimit = 64'd2_000_000;

  typedef struct packed {
    logic        vvalid;
    logic [31:0] sdev;
    logic [63:0] var_q;
    logic [31:0] maxv;
    logic [31:0] minv;
    logic [31:0] meanv;
    logic [31:0] cnt;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [wrs_pkg::OutDataWidth-1:0] m_axis_tdata;

  welford_running_stats dut (.*);

  always #5 clk_i = ~clk_i;

  // running state of the predictor
  longint unsigned n_seen;
  longint          run_mean;
  bit [63:0]       m2_sum;
  longint          lo_seen, hi_seen;

  stats_t  stats_q[$];
  int      errors = 0;
  int      beats_out = 0;
  int      beats_in = 0;
  longint  cycles = 0;

  function automatic bit [63:0] sat_mul(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = a * b;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic bit [63:0] root64(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_stats();
    n_seen = 0; run_mean = 0; m2_sum = 0;
    lo_seen = 64'sh7FFF_FFFF;
    hi_seen = -64'sh8000_0000;
  endfunction

  // Welford update; result reflects state after this sample
  function automatic stats_t update_stats(logic [31:0] raw);
    longint v, d1, d2;
    bit [63:0] prod, sum, a1, a2, rt;
    stats_t r;
    v = longint'(signed'(raw));
    if (n_seen < ((64'd1 << CntW) - 1)) n_seen++;
    d1 = v - run_mean;
    run_mean += d1 / longint'(n_seen);
    d2 = v - run_mean;
    a1 = d1 < 0 ? -d1 : d1;
    a2 = d2 < 0 ? -d2 : d2;
    prod = ((d1 >= 0 && d2 >= 0) || (d1 <= 0 && d2 <= 0)) ? sat_mul(a1, a2) : 0;
    sum = m2_sum + prod;
    m2_sum = (sum < m2_sum) ? '1 : sum;
    if (v < lo_seen) lo_seen = v;
    if (v > hi_seen) hi_seen = v;
    r = '0;
    r.cnt = n_seen[31:0];
    r.meanv = run_mean[31:0];
    r.minv = lo_seen[31:0];
    r.maxv = hi_seen[31:0];
    if (n_seen >= 2) begin
      r.var_q = m2_sum / (n_seen - 1);
      rt = root64(r.var_q);
      r.sdev = rt[31:0];
      r.vvalid = 1'b1;
    end
    return r;
  endfunction

  // sender: one beat, preceded by a random gap now and then
  task automatic send_sample(logic [31:0] s);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    stats_q.insert(stats_q.size(), update_stats(s));
    beats_in++;
  endtask

  // receiver stall pattern: alternating stretches of ready and random stalls
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles[9]) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  // result checker
  always @(posedge clk_i) begin
    stats_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(stats_t)-1:0];
      beats_out++;
      if (stats_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = stats_q.pop_front();
        if (got.cnt !== want.cnt) begin
          $display("%0t: count exp %0d got %0d", $time, want.cnt, got.cnt); errors++;
        end
        if (got.meanv !== want.meanv) begin
          $display("%0t: mean exp %h got %h", $time, want.meanv, got.meanv); errors++;
        end
        if (got.minv !== want.minv) begin
          $display("%0t: min exp %h got %h", $time, want.minv, got.minv); errors++;
        end
        if (got.maxv !== want.maxv) begin
          $display("%0t: max exp %h got %h", $time, want.maxv, got.maxv); errors++;
        end
        if (got.var_q !== want.var_q) begin
          $display("%0t: variance exp %h got %h", $time, want.var_q, got.var_q); errors++;
        end
        if (got.sdev !== want.sdev) begin
          $display("%0t: std_dev exp %h got %h", $time, want.sdev, got.sdev); errors++;
        end
        if (got.vvalid !== want.vvalid) begin
          $display("%0t: valid exp %b got %b", $time, want.vvalid, got.vvalid); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // extremes: first sample alone, then full-scale swings that saturate M2
  task automatic test_extremes();
    send_sample(32'h0000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0001_0000);
  endtask

  // constant run: six equal samples on top of the state left by the extremes, then two large samples
  task automatic test_constant();
    repeat (6) send_sample(32'hFFFE_8000);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);
  endtask

  // random: mostly moderate values, some full scale, with occasional long source gaps
  task automatic test_random();
    logic [31:0] s;
    for (int i = 0; i < RandItems; i++) begin
      case ($urandom_range(0, 9))
        0: s = $urandom;
        1, 2: s = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
        default: s = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000 + 32'h0010_0000;
      endcase
      send_sample(s);
      if ($urandom_range(0, 40) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    clear_stats();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_constant();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Fed %0d samples incl. full-scale extremes and constant runs;", beats_in);
    $display("checked %0d result beats under random source gaps and sink stalls.", beats_out);
    if (errors == 0 && stats_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
